// ===== sv/bbsz_pkg.sv =====
`timescale 1ns / 1ps
package bbsz_pkg;

   // coefficient and bilinear constant formats
   localparam int CW  = 32;            // coefficient width, Q8.24
   localparam int FB  = 24;            // coefficient fraction bits
   localparam int KW  = 32;            // k width, unsigned Q12.20
   localparam int KF  = 20;            // k fraction bits

   // product and sum widths
   localparam int PKW  = 2 * KW;       // k*k exact
   localparam int KKW  = PKW - KF;     // k*k rounded, Q24.20
   localparam int P1W  = CW + KW;      // |x1|*k exact
   localparam int T1W  = P1W - KF;     // |x1|*k rounded
   localparam int P2W  = CW + KKW;     // |x2|*kk exact
   localparam int T2W  = P2W - KF;     // |x2|*kk rounded
   localparam int SW   = T2W + 2;      // signed z-plane sums
   localparam int MW   = SW - 1;       // magnitude of a sum

   // divider geometry
   localparam int QW   = CW;           // quotient bits kept
   localparam int NSH  = QW - FB;      // numerator bits below the first remainder

   // latency
   localparam int PRE_LAT = 6;
   localparam int DIV_LAT = QW + 2;
   localparam int LAT     = PRE_LAT + DIV_LAT + 1;

   // half LSB at the k fraction point
   localparam logic [P2W:0] RND = (P2W + 1)'(1) << (KF - 1);

   // clip limits on the rounded quotient magnitude
   localparam logic [QW:0] POS_LIM = {2'b00, {(QW - 1){1'b1}}};
   localparam logic [QW:0] NEG_LIM = {2'b01, {(QW - 1){1'b0}}};
   localparam logic [CW-1:0] COEF_MAX = {1'b0, {(CW - 1){1'b1}}};
   localparam logic [CW-1:0] COEF_MIN = {1'b1, {(CW - 1){1'b0}}};

   typedef struct packed {
      logic [CW-1:0] coef;
      logic          sat;
   } div_res_type;

   // magnitude of a signed coefficient, exact for the most negative code
   function automatic logic [CW-1:0] coef_mag(input logic [CW-1:0] x);
      logic [CW-1:0] m;
      m = x[CW-1] ? (~x + CW'(1)) : x;
      return m;
   endfunction

endpackage

// ===== sv/bbsz_div.sv =====
`timescale 1ns / 1ps
module bbsz_div (
   input  logic                      clock,
   input  logic [bbsz_pkg::MW-1:0]   num_mag,
   input  logic [bbsz_pkg::MW-1:0]   den_mag,
   input  logic                      neg,
   output bbsz_pkg::div_res_type     res
);

   localparam int MW  = bbsz_pkg::MW;
   localparam int QW  = bbsz_pkg::QW;
   localparam int NSH = bbsz_pkg::NSH;
   localparam int FB  = bbsz_pkg::FB;

   logic [MW-1:0] rem_ff [0:QW];
   logic [QW-1:0] nq_ff  [0:QW];
   logic [MW-1:0] den_ff [0:QW];
   logic          neg_ff [0:QW];
   logic          big_ff [0:QW];

   logic          big_in;
   logic [MW-1:0] rem_in;
   logic [QW-1:0] nq_in;

   // flag quotients of 2^QW and above, split the scaled numerator
   assign big_in = {{NSH{1'b0}}, num_mag} >= {den_mag, {NSH{1'b0}}};
   assign rem_in = num_mag >> NSH;
   assign nq_in  = {num_mag[NSH-1:0], {FB{1'b0}}};

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in;
      nq_ff[0]  <= nq_in;
      den_ff[0] <= den_mag;
      neg_ff[0] <= neg;
      big_ff[0] <= big_in;
   end

   // one restoring step per stage: shift in a numerator bit, shift out a quotient bit
   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [MW:0]   trial;
      logic [MW:0]   diff;
      logic          ge;
      logic [MW-1:0] step_rem_in;

      assign trial       = {rem_ff[i], nq_ff[i][QW-1]};
      assign diff        = trial - {1'b0, den_ff[i]};
      assign ge          = trial >= {1'b0, den_ff[i]};
      assign step_rem_in = ge ? diff[MW-1:0] : trial[MW-1:0];

      always_ff @(posedge clock) begin
         rem_ff[i+1] <= step_rem_in;
         nq_ff[i+1]  <= {nq_ff[i][QW-2:0], ge};
         den_ff[i+1] <= den_ff[i];
         neg_ff[i+1] <= neg_ff[i];
         big_ff[i+1] <= big_ff[i];
      end
   end

   logic                  rnd_up;
   logic [QW:0]           q1;
   logic                  sat_in;
   logic [bbsz_pkg::CW-1:0] coef_in;
   bbsz_pkg::div_res_type res_ff;

   // round half away from zero, then clip to the signed range
   assign rnd_up = {rem_ff[QW], 1'b0} >= {1'b0, den_ff[QW]};
   assign q1     = {1'b0, nq_ff[QW]} + {{QW{1'b0}}, rnd_up};

   always_comb begin
      if (!neg_ff[QW]) begin
         sat_in  = big_ff[QW] || (q1 > bbsz_pkg::POS_LIM);
         coef_in = sat_in ? bbsz_pkg::COEF_MAX : q1[QW-1:0];
      end else begin
         sat_in  = big_ff[QW] || (q1 > bbsz_pkg::NEG_LIM);
         coef_in = sat_in ? bbsz_pkg::COEF_MIN : (~q1[QW-1:0] + QW'(1));
      end
   end

   always_ff @(posedge clock) begin
      res_ff.coef <= coef_in;
      res_ff.sat  <= sat_in;
   end

   assign res = res_ff;

endmodule

// ===== sv/biquad_bilinear_s_to_z_top.sv =====
`timescale 1ns / 1ps
// Bilinear s-to-z mapping of one biquad coefficient set per transfer. A set
// presented with req_start is taken in every cycle (busy stays low) and its
// result appears on the rsp_ ports with rsp_valid for one cycle; the receiver
// cannot stall and a new set may enter each cycle. The path runs through the
// multiply, round and sum stages, then a 34-stage divider (one quotient bit
// per stage for 32 bits, plus setup and rounding), then the output register.
// Outputs are Q8.24 with a0 = 1; rsp_saturated marks clipped quotients and
// rsp_div_zero a zero denominator (all zero).
module biquad_bilinear_s_to_z_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        busy,
   input  logic [31:0] req_s_b0,
   input  logic [31:0] req_s_b1,
   input  logic [31:0] req_s_b2,
   input  logic [31:0] req_s_a0,
   input  logic [31:0] req_s_a1,
   input  logic [31:0] req_s_a2,
   input  logic [31:0] req_k_factor,
   output logic        rsp_valid,
   output logic [31:0] rsp_z_b0,
   output logic [31:0] rsp_z_b1,
   output logic [31:0] rsp_z_b2,
   output logic [31:0] rsp_z_a1,
   output logic [31:0] rsp_z_a2,
   output logic        rsp_div_zero,
   output logic        rsp_saturated
);

   localparam int CW  = bbsz_pkg::CW;
   localparam int KF  = bbsz_pkg::KF;
   localparam int PKW = bbsz_pkg::PKW;
   localparam int KKW = bbsz_pkg::KKW;
   localparam int P1W = bbsz_pkg::P1W;
   localparam int T1W = bbsz_pkg::T1W;
   localparam int P2W = bbsz_pkg::P2W;
   localparam int T2W = bbsz_pkg::T2W;
   localparam int SW  = bbsz_pkg::SW;
   localparam int MW  = bbsz_pkg::MW;
   localparam int LAT = bbsz_pkg::LAT;
   localparam int DIV_LAT = bbsz_pkg::DIV_LAT;

   // the pipeline takes a set in every cycle
   assign busy = 1'b0;

   // valid line, one bit per register stage
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], req_start};
      end
   end

   // stage 1: k*k and first-order products on magnitudes
   logic [PKW-1:0] s1_pkk_in, s1_pkk_ff;
   logic [P1W-1:0] s1_pb1_in, s1_pb1_ff, s1_pa1_in, s1_pa1_ff;
   logic [CW-1:0]  s1_b0_ff, s1_a0_ff, s1_b2m_ff, s1_a2m_ff;
   logic           s1_b1n_ff, s1_a1n_ff, s1_b2n_ff, s1_a2n_ff;

   assign s1_pkk_in = PKW'(req_k_factor) * PKW'(req_k_factor);
   assign s1_pb1_in = P1W'(bbsz_pkg::coef_mag(req_s_b1)) * P1W'(req_k_factor);
   assign s1_pa1_in = P1W'(bbsz_pkg::coef_mag(req_s_a1)) * P1W'(req_k_factor);

   always_ff @(posedge clock) begin
      s1_pkk_ff <= s1_pkk_in;
      s1_pb1_ff <= s1_pb1_in;
      s1_pa1_ff <= s1_pa1_in;
      s1_b0_ff  <= req_s_b0;
      s1_a0_ff  <= req_s_a0;
      s1_b2m_ff <= bbsz_pkg::coef_mag(req_s_b2);
      s1_a2m_ff <= bbsz_pkg::coef_mag(req_s_a2);
      s1_b1n_ff <= req_s_b1[CW-1];
      s1_a1n_ff <= req_s_a1[CW-1];
      s1_b2n_ff <= req_s_b2[CW-1];
      s1_a2n_ff <= req_s_a2[CW-1];
   end

   // stage 2: round k*k, round and sign the first-order k terms
   logic [PKW:0]   s2_kkr, s2_b1r, s2_a1r;
   logic [SW-1:0]  s2_b1u, s2_a1u;
   logic [KKW-1:0] s2_kk_ff;
   logic [SW-1:0]  s2_t1b_ff, s2_t1a_ff;
   logic [CW-1:0]  s2_b0_ff, s2_a0_ff, s2_b2m_ff, s2_a2m_ff;
   logic           s2_b2n_ff, s2_a2n_ff;

   assign s2_kkr = {1'b0, s1_pkk_ff} + bbsz_pkg::RND[PKW:0];
   assign s2_b1r = {1'b0, s1_pb1_ff} + bbsz_pkg::RND[P1W:0];
   assign s2_a1r = {1'b0, s1_pa1_ff} + bbsz_pkg::RND[P1W:0];
   assign s2_b1u = {{(SW-T1W){1'b0}}, s2_b1r[KF +: T1W]};
   assign s2_a1u = {{(SW-T1W){1'b0}}, s2_a1r[KF +: T1W]};

   always_ff @(posedge clock) begin
      s2_kk_ff  <= s2_kkr[KF +: KKW];
      s2_t1b_ff <= s1_b1n_ff ? (~s2_b1u + SW'(1)) : s2_b1u;
      s2_t1a_ff <= s1_a1n_ff ? (~s2_a1u + SW'(1)) : s2_a1u;
      s2_b0_ff  <= s1_b0_ff;
      s2_a0_ff  <= s1_a0_ff;
      s2_b2m_ff <= s1_b2m_ff;
      s2_a2m_ff <= s1_a2m_ff;
      s2_b2n_ff <= s1_b2n_ff;
      s2_a2n_ff <= s1_a2n_ff;
   end

   // stage 3: second-order products x2*kk
   logic [P2W-1:0] s3_pb2_ff, s3_pa2_ff;
   logic [SW-1:0]  s3_t1b_ff, s3_t1a_ff;
   logic [CW-1:0]  s3_b0_ff, s3_a0_ff;
   logic           s3_b2n_ff, s3_a2n_ff;

   always_ff @(posedge clock) begin
      s3_pb2_ff <= P2W'(s2_b2m_ff) * P2W'(s2_kk_ff);
      s3_pa2_ff <= P2W'(s2_a2m_ff) * P2W'(s2_kk_ff);
      s3_t1b_ff <= s2_t1b_ff;
      s3_t1a_ff <= s2_t1a_ff;
      s3_b0_ff  <= s2_b0_ff;
      s3_a0_ff  <= s2_a0_ff;
      s3_b2n_ff <= s2_b2n_ff;
      s3_a2n_ff <= s2_a2n_ff;
   end

   // stage 4: round and sign the second-order terms
   logic [P2W:0]  s4_b2r, s4_a2r;
   logic [SW-1:0] s4_b2u, s4_a2u;
   logic [SW-1:0] s4_t2b_ff, s4_t2a_ff, s4_t1b_ff, s4_t1a_ff;
   logic [CW-1:0] s4_b0_ff, s4_a0_ff;

   assign s4_b2r = {1'b0, s3_pb2_ff} + bbsz_pkg::RND;
   assign s4_a2r = {1'b0, s3_pa2_ff} + bbsz_pkg::RND;
   assign s4_b2u = {{(SW-T2W){1'b0}}, s4_b2r[KF +: T2W]};
   assign s4_a2u = {{(SW-T2W){1'b0}}, s4_a2r[KF +: T2W]};

   always_ff @(posedge clock) begin
      s4_t2b_ff <= s3_b2n_ff ? (~s4_b2u + SW'(1)) : s4_b2u;
      s4_t2a_ff <= s3_a2n_ff ? (~s4_a2u + SW'(1)) : s4_a2u;
      s4_t1b_ff <= s3_t1b_ff;
      s4_t1a_ff <= s3_t1a_ff;
      s4_b0_ff  <= s3_b0_ff;
      s4_a0_ff  <= s3_a0_ff;
   end

   // stage 5: z-plane sums
   logic [SW-1:0] s5_b0x, s5_a0x, s5_bsum, s5_asum, s5_bdif, s5_adif;
   logic [SW-1:0] s5_bz_ff [0:2];
   logic [SW-1:0] s5_az_ff [0:2];

   assign s5_b0x  = {{(SW-CW){s4_b0_ff[CW-1]}}, s4_b0_ff};
   assign s5_a0x  = {{(SW-CW){s4_a0_ff[CW-1]}}, s4_a0_ff};
   assign s5_bsum = s5_b0x + s4_t2b_ff;
   assign s5_asum = s5_a0x + s4_t2a_ff;
   assign s5_bdif = s5_b0x - s4_t2b_ff;
   assign s5_adif = s5_a0x - s4_t2a_ff;

   always_ff @(posedge clock) begin
      s5_bz_ff[0] <= s5_bsum + s4_t1b_ff;
      s5_bz_ff[1] <= {s5_bdif[SW-2:0], 1'b0};
      s5_bz_ff[2] <= s5_bsum - s4_t1b_ff;
      s5_az_ff[0] <= s5_asum + s4_t1a_ff;
      s5_az_ff[1] <= {s5_adif[SW-2:0], 1'b0};
      s5_az_ff[2] <= s5_asum - s4_t1a_ff;
   end

   // stage 6: magnitudes, quotient signs, zero denominator
   logic [SW-1:0] s6_num [0:4];
   logic [SW-1:0] s6_den_abs;
   logic [MW-1:0] s6_num_ff [0:4];
   logic [MW-1:0] s6_den_ff;
   logic          s6_neg_ff [0:4];
   logic          s6_dz_ff;

   assign s6_num[0] = s5_bz_ff[0];
   assign s6_num[1] = s5_bz_ff[1];
   assign s6_num[2] = s5_bz_ff[2];
   assign s6_num[3] = s5_az_ff[1];
   assign s6_num[4] = s5_az_ff[2];
   assign s6_den_abs = s5_az_ff[0][SW-1] ? (~s5_az_ff[0] + SW'(1)) : s5_az_ff[0];

   for (genvar g = 0; g < 5; g++) begin : g_mag
      logic [SW-1:0] num_abs;
      assign num_abs = s6_num[g][SW-1] ? (~s6_num[g] + SW'(1)) : s6_num[g];
      always_ff @(posedge clock) begin
         s6_num_ff[g] <= num_abs[MW-1:0];
         s6_neg_ff[g] <= s6_num[g][SW-1] ^ s5_az_ff[0][SW-1];
      end
   end

   always_ff @(posedge clock) begin
      s6_den_ff <= s6_den_abs[MW-1:0];
      s6_dz_ff  <= (s5_az_ff[0] == '0);
   end

   // normalizing dividers, one per output coefficient
   bbsz_pkg::div_res_type div_res [0:4];

   for (genvar g = 0; g < 5; g++) begin : g_div
      bbsz_div u_div (
         .clock   (clock),
         .num_mag (s6_num_ff[g]),
         .den_mag (s6_den_ff),
         .neg     (s6_neg_ff[g]),
         .res     (div_res[g])
      );
   end

   // carry the zero-denominator flag alongside the dividers
   logic dz_ff [0:DIV_LAT-1];
   always_ff @(posedge clock) begin
      dz_ff[0] <= s6_dz_ff;
      for (int i = 1; i < DIV_LAT; i++) begin
         dz_ff[i] <= dz_ff[i-1];
      end
   end

   // output register: zero everything on a zero denominator
   logic [CW-1:0] out_coef_ff [0:4];
   logic          out_dz_ff, out_sat_ff;
   logic          sat_any;

   assign sat_any = div_res[0].sat | div_res[1].sat | div_res[2].sat
                  | div_res[3].sat | div_res[4].sat;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 5; i++) begin
         out_coef_ff[i] <= dz_ff[DIV_LAT-1] ? '0 : div_res[i].coef;
      end
      out_dz_ff  <= dz_ff[DIV_LAT-1];
      out_sat_ff <= !dz_ff[DIV_LAT-1] && sat_any;
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_z_b0      = out_coef_ff[0];
   assign rsp_z_b1      = out_coef_ff[1];
   assign rsp_z_b2      = out_coef_ff[2];
   assign rsp_z_a1      = out_coef_ff[3];
   assign rsp_z_a2      = out_coef_ff[4];
   assign rsp_div_zero  = out_dz_ff;
   assign rsp_saturated = out_sat_ff;

   // every transfer in yields one result after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      req_start |-> ##(bbsz_pkg::LAT) rsp_valid)
      else $error("result missing after accepted set");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start, bbsz_pkg::LAT))
      else $error("result without a matching set");

   a_dz_clear : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero) |-> (!rsp_saturated && rsp_z_b0 == '0
         && rsp_z_b1 == '0 && rsp_z_b2 == '0 && rsp_z_a1 == '0 && rsp_z_a2 == '0))
      else $error("zero denominator result not cleared");

endmodule
